[rtl/core/abm_pkg.sv]
// ----------------------------------------------------------------------------
// abm_pkg
// shared types and constants of the allocate-on-write block map
// ----------------------------------------------------------------------------
package abm_pkg;

  localparam int FILE_COUNT      = 16;
  localparam int BLOCKS_PER_FILE = 256;
  localparam int PHYS_BLOCKS     = 4096;

  localparam int BLOCK_BYTES  = 2 * 1024 * 1024;
  localparam int SECTOR_BYTES = 512;

  localparam int FILE_W      = $clog2(FILE_COUNT);
  localparam int LBLK_W      = $clog2(BLOCKS_PER_FILE);
  localparam int PBLK_W      = $clog2(PHYS_BLOCKS);
  localparam int MAP_DEPTH   = FILE_COUNT * BLOCKS_PER_FILE;
  localparam int MAP_AW      = FILE_W + LBLK_W;
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int SECT_SHIFT  = $clog2(SECTOR_BYTES);
  localparam int SOFF_W      = BLOCK_SHIFT - SECT_SHIFT;
  localparam int OFFSET_W    = 29;
  localparam int SECTOR_W    = 24;
  localparam int COUNT_W     = 9;
  localparam int STATUS_W    = 2;
  localparam int ENTRY_W     = PBLK_W + 1;

  localparam logic [PBLK_W-1:0] LAST_FREE  = PBLK_W'(PHYS_BLOCKS - 1);
  localparam logic [MAP_AW-1:0] MAP_LAST   = MAP_AW'(MAP_DEPTH - 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_FETCH,
    BK_EXEC
  } back_state_t;

  typedef struct packed {
    logic              is_write;
    logic [FILE_W-1:0] file_id;
    logic [LBLK_W-1:0] block_index;
    logic [SOFF_W-1:0] sector_offset;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

[rtl/core/abm_if.sv]
// ----------------------------------------------------------------------------
// abm_if
// request and response channels of the block map
// ----------------------------------------------------------------------------
interface abm_req_if;
  logic        valid;
  logic        ready;
  logic        is_write;
  logic [3:0]  file_id;
  logic [28:0] byte_offset;

  modport source(output valid, is_write, file_id, byte_offset, input ready);
  modport sink(input valid, is_write, file_id, byte_offset, output ready);
endinterface

interface abm_rsp_if;
  logic        valid;
  logic        ready;
  logic [23:0] sector_address;
  logic [1:0]  status;
  logic        newly_allocated;
  logic [8:0]  file_block_count;

  modport source(output valid, sector_address, status, newly_allocated, file_block_count,
                 input ready);
  modport sink(input valid, sector_address, status, newly_allocated, file_block_count,
               output ready);
endinterface

[rtl/core/allocate_on_write_block_map.sv]
// ----------------------------------------------------------------------------
// allocate_on_write_block_map
// thin-provisioning block map: file and byte offset to physical sector lba
// ----------------------------------------------------------------------------
// After reset the block clears all 4096 entries of the map memory, one entry
// per cycle, with req.ready low. Afterwards each request passes through the
// lookup unit: a fetch state issues the registered map memory read, and an
// exec state decides, writes a new mapping and loads the response register,
// waiting while an untaken response holds it. Requests are buffered in a
// two-entry command queue; a waiting response does not block it from filling.
module allocate_on_write_block_map (
  input logic       clk,
  input logic       rst,
  abm_req_if.sink   req,
  abm_rsp_if.source rsp
);

  abm_pkg::queue_head_t  head;
  abm_pkg::back_status_t bstat;
  logic                  pop;

  abm_front u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .bstat(bstat),
    .head (head),
    .pop  (pop)
  );

  abm_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .bstat(bstat),
    .rsp  (rsp)
  );

endmodule

[rtl/core/abm_ram.sv]
// ----------------------------------------------------------------------------
// abm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module abm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/abm_front.sv]
// ----------------------------------------------------------------------------
// abm_front
// accepts requests, splits the offset into map index and sector offset,
// and holds them in a short command queue
// ----------------------------------------------------------------------------
module abm_front (
  input  logic                 clk,
  input  logic                 rst,
  abm_req_if.sink              req,
  input  abm_pkg::back_status_t bstat,
  output abm_pkg::queue_head_t head,
  input  logic                 pop
);

  abm_pkg::cmd_t                   entries [abm_pkg::QUEUE_DEPTH];
  logic [abm_pkg::QPTR_W-1:0]      wr_ptr;
  logic [abm_pkg::QPTR_W-1:0]      rd_ptr;
  logic [abm_pkg::QCNT_W-1:0]      fill;
  abm_pkg::cmd_t                   cmd_in;
  logic                            push;

  always_comb begin
    cmd_in.is_write      = req.is_write;
    cmd_in.file_id       = req.file_id;
    cmd_in.block_index   = req.byte_offset[abm_pkg::BLOCK_SHIFT +: abm_pkg::LBLK_W];
    cmd_in.sector_offset = req.byte_offset[abm_pkg::SECT_SHIFT +: abm_pkg::SOFF_W];
  end

  assign req.ready  = !bstat.clearing && (fill != abm_pkg::QCNT_W'(abm_pkg::QUEUE_DEPTH));
  assign push       = req.valid && req.ready;
  assign head.valid = (fill != '0);
  assign head.cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[rtl/core/abm_back.sv]
// ----------------------------------------------------------------------------
// abm_back
// clears the map after reset, then looks up each command, allocates on an
// unmapped write unless the allocator is full, and registers the response
// ----------------------------------------------------------------------------
module abm_back (
  input  logic                  clk,
  input  logic                  rst,
  input  abm_pkg::queue_head_t  head,
  output logic                  pop,
  output abm_pkg::back_status_t bstat,
  abm_rsp_if.source             rsp
);

  abm_pkg::back_state_t             state;
  abm_pkg::back_state_t             state_next;
  logic [abm_pkg::MAP_AW-1:0]       clr_addr;
  abm_pkg::cmd_t                    cmd;
  logic [abm_pkg::PBLK_W-1:0]       next_free;
  logic [abm_pkg::COUNT_W-1:0]      counts [abm_pkg::FILE_COUNT];

  logic                             ram_we;
  logic [abm_pkg::MAP_AW-1:0]       ram_waddr;
  logic [abm_pkg::ENTRY_W-1:0]      ram_wdata;
  logic                             ram_re;
  logic [abm_pkg::ENTRY_W-1:0]      ram_rdata;

  logic                             out_valid;
  logic [abm_pkg::SECTOR_W-1:0]     out_sector;
  abm_pkg::status_t                 out_status;
  logic                             out_fresh;
  logic [abm_pkg::COUNT_W-1:0]      out_count;

  logic                             out_free;
  logic                             load;
  logic                             hit;
  logic                             alloc;
  logic [abm_pkg::COUNT_W-1:0]      cur_count;
  logic [abm_pkg::SECTOR_W-1:0]     res_sector;
  abm_pkg::status_t                 res_status;
  logic [abm_pkg::COUNT_W-1:0]      res_count;

  abm_ram #(
    .WIDTH(abm_pkg::ENTRY_W),
    .DEPTH(abm_pkg::MAP_DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr({head.cmd.file_id, head.cmd.block_index}),
    .rdata(ram_rdata)
  );

  assign out_free       = !out_valid || rsp.ready;
  assign bstat.clearing = (state == abm_pkg::BK_CLEAR);

  // lookup result
  always_comb begin
    hit        = ram_rdata[abm_pkg::PBLK_W];
    cur_count  = counts[cmd.file_id];
    alloc      = 1'b0;
    res_sector = '0;
    res_status = abm_pkg::ST_OK;
    res_count  = cur_count;
    if (hit) begin
      res_sector = {ram_rdata[abm_pkg::PBLK_W-1:0], cmd.sector_offset};
    end else if (!cmd.is_write) begin
      res_status = abm_pkg::ST_UNMAPPED;
    end else if (next_free >= abm_pkg::LAST_FREE) begin
      res_status = abm_pkg::ST_FULL;
    end else begin
      alloc      = 1'b1;
      res_sector = {next_free, cmd.sector_offset};
      res_count  = cur_count + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      abm_pkg::BK_CLEAR: begin
        if (clr_addr == abm_pkg::MAP_LAST) begin
          state_next = abm_pkg::BK_FETCH;
        end
      end
      abm_pkg::BK_FETCH: begin
        if (head.valid) begin
          state_next = abm_pkg::BK_EXEC;
        end
      end
      abm_pkg::BK_EXEC: begin
        if (out_free) begin
          state_next = abm_pkg::BK_FETCH;
        end
      end
      default: state_next = abm_pkg::BK_CLEAR;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    ram_re    = 1'b0;
    pop       = 1'b0;
    load      = 1'b0;
    unique case (state)
      abm_pkg::BK_CLEAR: begin
        ram_we = 1'b1;
      end
      abm_pkg::BK_FETCH: begin
        ram_re = head.valid;
        pop    = head.valid;
      end
      abm_pkg::BK_EXEC: begin
        load      = out_free;
        ram_we    = out_free && alloc;
        ram_waddr = {cmd.file_id, cmd.block_index};
        ram_wdata = {1'b1, next_free};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head.cmd;
    end
    if (load) begin
      out_sector <= res_sector;
      out_status <= res_status;
      out_fresh  <= alloc;
      out_count  <= res_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= abm_pkg::BK_CLEAR;
      clr_addr  <= '0;
      next_free <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < abm_pkg::FILE_COUNT; i++) begin
        counts[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == abm_pkg::BK_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
        if (alloc) begin
          next_free           <= next_free + 1'b1;
          counts[cmd.file_id] <= res_count;
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.sector_address   = out_sector;
  assign rsp.status           = out_status;
  assign rsp.newly_allocated  = out_fresh;
  assign rsp.file_block_count = out_count;

endmodule

[rtl/core/abm_checker.sv]
// ----------------------------------------------------------------------------
// abm_checker
// port-level checks of the block map, bound to the top level
// ----------------------------------------------------------------------------
module abm_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [23:0] sector_address,
  input logic [1:0]  status,
  input logic        newly_allocated,
  input logic [8:0]  file_block_count
);

  // map clear pass holds off requests right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request accepted during map clear");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != abm_pkg::ST_OK |-> sector_address == '0 && !newly_allocated)
    else $error("failed transaction carries an address or allocation");

  a_alloc_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && newly_allocated |-> status == abm_pkg::ST_OK && file_block_count != '0)
    else $error("allocation without ok status or block count");

endmodule

bind allocate_on_write_block_map abm_checker u_abm_checker (
  .clk             (clk),
  .rst             (rst),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .sector_address  (rsp.sector_address),
  .status          (rsp.status),
  .newly_allocated (rsp.newly_allocated),
  .file_block_count(rsp.file_block_count)
);

[dv/block_map_monitor.sv]
// ----------------------------------------------------------------------------
// block_map_monitor
// watches both channels of the block map, predicts each response from its own
// copy of the per-file maps and the block allocator, and compares field by field
// ----------------------------------------------------------------------------
module block_map_monitor
  import abm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  abm_req_if   req,
  abm_rsp_if   rsp,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    status_t             status;
    logic                fresh;
    logic [COUNT_W-1:0]  count;
  } map_result_t;

  logic              slot_mapped [MAP_DEPTH];
  logic [PBLK_W-1:0] slot_block  [MAP_DEPTH];
  logic [COUNT_W-1:0] file_blocks [FILE_COUNT];
  logic [PBLK_W-1:0] alloc_next;

  map_result_t awaited_q[$];

  function automatic map_result_t translate_access(logic wr, logic [FILE_W-1:0] fid,
                                                   logic [OFFSET_W-1:0] off);
    logic [MAP_AW-1:0] slot;
    map_result_t       res;
    slot       = {fid, off[BLOCK_SHIFT +: LBLK_W]};
    res.sector = '0;
    res.status = ST_OK;
    res.fresh  = 1'b0;
    if (!slot_mapped[slot]) begin
      if (!wr) begin
        res.status = ST_UNMAPPED;
      end else if (alloc_next == LAST_FREE) begin
        res.status = ST_FULL;
      end else begin
        slot_block[slot]  = alloc_next;
        slot_mapped[slot] = 1'b1;
        alloc_next        = alloc_next + 1'b1;
        file_blocks[fid]  = file_blocks[fid] + 1'b1;
        res.fresh         = 1'b1;
      end
    end
    if (res.status == ST_OK)
      res.sector = {slot_block[slot], off[SECT_SHIFT +: SOFF_W]};
    res.count = file_blocks[fid];
    return res;
  endfunction

  task automatic report_field(string field, longint unsigned want_v, longint unsigned got_v);
    $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want_v,
             got_v);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    map_result_t want;
    if (rst) begin
      foreach (slot_mapped[i]) begin
        slot_mapped[i] = 1'b0;
        slot_block[i]  = '0;
      end
      foreach (file_blocks[i]) file_blocks[i] = '0;
      alloc_next = '0;
      awaited_q.delete();
      errors = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_q.size() == 0) begin
          $display("%0t ns: response with none expected, actual sector 0x%0h status %0d",
                   $time, rsp.sector_address, rsp.status);
          errors++;
        end else begin
          want = awaited_q.pop_front();
          if (rsp.sector_address !== want.sector)
            report_field("sector_address", want.sector, rsp.sector_address);
          if (rsp.status !== want.status)
            report_field("status", want.status, rsp.status);
          if (rsp.newly_allocated !== want.fresh)
            report_field("newly_allocated", want.fresh, rsp.newly_allocated);
          if (rsp.file_block_count !== want.count)
            report_field("file_block_count", want.count, rsp.file_block_count);
        end
      end
      if (req.valid && req.ready)
        awaited_q.push_back(translate_access(req.is_write, req.file_id, req.byte_offset));
    end
    pending = awaited_q.size();
  end

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// allocate-on-write block map testbench: directed corner accesses, a random
// mix around a few hot logical blocks, a write sweep over all map entries but
// one spare that drains the allocator, then random traffic on the full device
// ----------------------------------------------------------------------------
module tb;
  import abm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              CYCLE_LIMIT = 400000;
  localparam int              MIX_ITEMS   = 1400;
  localparam int              TAIL_ITEMS  = 200;
  localparam logic [FILE_W-1:0] SPARE_FILE  = FILE_W'(5);
  localparam logic [LBLK_W-1:0] SPARE_BLOCK = LBLK_W'(8'h5A);

  logic clk = 1'b0;
  logic rst;
  logic calm;
  logic spare_open;
  int   errors;
  int   pending;
  int   cycle_count = 0;

  abm_req_if req();
  abm_rsp_if rsp();

  allocate_on_write_block_map dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  block_map_monitor map_monitor (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .errors(errors),
    .pending(pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[allocate_on_write_block_map] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp.ready <= calm || ($urandom_range(0, 99) >= 7);
  end

  // one spare entry is kept unmapped so the sweep ends with the allocator full
  task automatic send_access(logic wr, logic [FILE_W-1:0] fid, logic [OFFSET_W-1:0] off);
    if (!spare_open && fid == SPARE_FILE && off[BLOCK_SHIFT +: LBLK_W] == SPARE_BLOCK)
      wr = 1'b0;
    while (!calm && $urandom_range(0, 99) < 7) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid       <= 1'b1;
    req.is_write    <= wr;
    req.file_id     <= fid;
    req.byte_offset <= off;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  task automatic send_random(logic hot);
    logic [OFFSET_W-1:0] off;
    off = OFFSET_W'($urandom);
    if (hot)
      off[BLOCK_SHIFT +: LBLK_W] = LBLK_W'($urandom_range(0, 7));
    send_access(1'($urandom_range(0, 1)), FILE_W'($urandom_range(0, FILE_COUNT - 1)), off);
  endtask

  initial begin
    logic [OFFSET_W-1:0] off;
    rst             = 1'b1;
    calm            = 1'b0;
    spare_open      = 1'b0;
    req.valid       = 1'b0;
    req.is_write    = 1'b0;
    req.file_id     = '0;
    req.byte_offset = '0;
    rsp.ready       = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_access(1'b0, 4'd0, 29'h0000000);
    send_access(1'b1, 4'd0, 29'h0000000);
    send_access(1'b0, 4'd0, 29'h01FFFFF);
    send_access(1'b1, 4'd0, 29'h01FFE00);
    send_access(1'b1, 4'd15, 29'h1FFFFFFF);
    send_access(1'b0, 4'd15, 29'h1FE00000);
    send_access(1'b0, 4'd15, 29'h0000000);
    send_access(1'b1, 4'd10, 29'h0AAAAAAA);
    send_access(1'b1, 4'd5, 29'h15555555);
    send_access(1'b0, 4'd10, 29'h0AAA0000);
    send_access(1'b0, 4'd5, 29'h15555555);
    send_access(1'b1, 4'd3, 29'h0200000);
    send_access(1'b0, 4'd3, 29'h0200001);
    send_access(1'b0, SPARE_FILE, {SPARE_BLOCK, 21'h0});
    send_access(1'b1, 4'd15, 29'h1FFFFFFF);

    for (int n = 0; n < MIX_ITEMS; n++)
      send_random($urandom_range(0, 9) < 6);

    for (int slot = 0; slot < MAP_DEPTH; slot++) begin
      calm = (slot >= 1024 && slot < 2560);
      off  = OFFSET_W'($urandom);
      off[BLOCK_SHIFT +: LBLK_W] = LBLK_W'(slot % BLOCKS_PER_FILE);
      send_access(1'b1, FILE_W'(slot / BLOCKS_PER_FILE), off);
    end
    calm = 1'b0;

    spare_open = 1'b1;
    for (int n = 0; n < TAIL_ITEMS; n++) begin
      if ($urandom_range(0, 9) < 4) begin
        off = OFFSET_W'($urandom);
        off[BLOCK_SHIFT +: LBLK_W] = SPARE_BLOCK;
        send_access(1'($urandom_range(0, 1)), SPARE_FILE, off);
      end else begin
        send_random(1'b0);
      end
    end
    req.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("[allocate_on_write_block_map] OK");
    else
      $display("[allocate_on_write_block_map] ERROR");
    $finish;
  end

endmodule
